/* rtl/hdf_pkg.sv */
// ============================================================================
// hdf_pkg: shared types and helpers of the hex dump formatter
// Holds the microcode control word layout, its field codes and the
// character helpers used by the datapath.
// ============================================================================
package hdf_pkg;

    localparam int DEF_BYTES_PER_LINE = 16;
    localparam int UPC_W              = 4;

    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_DOT     = 8'h2E;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] PRINT_LOW    = 8'd32;
    localparam logic [7:0] PRINT_HIGH   = 8'd126;

    // Where the character of an emitting step comes from.
    typedef enum logic [2:0] {
        SRC_NONE,
        SRC_HEX_HI,
        SRC_HEX_LO,
        SRC_SPACE,
        SRC_STORE,
        SRC_NEWLINE
    } src_t;

    // Side effect of a step on the datapath registers.
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_ACCEPT,
        ACT_WRITE,
        ACT_K_FROM_POS,
        ACT_K_CLR,
        ACT_K_INC,
        ACT_K_NEXT,
        ACT_POS_CLR
    } act_t;

    // Jump condition of a step.
    typedef enum logic [3:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_POS_EVEN,
        COND_NO_LINE,
        COND_FULL,
        COND_K_EVEN,
        COND_K_LT_N,
        COND_K_MORE
    } cond_t;

    // How the end_of_run mark of an emitted character is decided.
    typedef enum logic [1:0] {
        LAST_NO,
        LAST_LO,
        LAST_SP,
        LAST_YES
    } last_t;

    typedef struct packed {
        src_t             src;
        act_t             act;
        last_t            last;
        cond_t            cond;
        logic [UPC_W-1:0] target;
    } ctrl_t;

    // Status flags from the datapath, tested by the jump conditions.
    typedef struct packed {
        logic no_input;
        logic pos_even;
        logic no_line;
        logic full;
        logic k_even;
        logic k_lt_n;
        logic k_more;
    } flags_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10)
        begin
            c = 8'h30 + {4'd0, nib};
        end
        else
        begin
            c = 8'h57 + {4'd0, nib};
        end
        return c;
    endfunction

    function automatic logic [7:0] printable(input logic [7:0] b);
        logic [7:0] c;
        if (b >= PRINT_LOW && b <= PRINT_HIGH)
        begin
            c = b;
        end
        else
        begin
            c = CHAR_DOT;
        end
        return c;
    endfunction

endpackage

/* rtl/hdf_ram.sv */
// ============================================================================
// hdf_ram: generic single-write, single-read RAM
// One write port and one read port with a registered, enabled read.
// ============================================================================
module hdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/hdf_seq.sv */
// ============================================================================
// hdf_seq: microcode sequencer of the hex dump formatter
// Step counter, control store and jump logic. The step counter moves only
// when the datapath lets the current step complete.
// ============================================================================
module hdf_seq
    import hdf_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   advance,
    input  flags_t flags,
    output ctrl_t  ctrl
);

    localparam logic [UPC_W-1:0] ST_WAIT     = 4'd0;
    localparam logic [UPC_W-1:0] ST_HEX_HI   = 4'd1;
    localparam logic [UPC_W-1:0] ST_HEX_LO   = 4'd2;
    localparam logic [UPC_W-1:0] ST_PAIR_SP  = 4'd3;
    localparam logic [UPC_W-1:0] ST_BRANCH   = 4'd4;
    localparam logic [UPC_W-1:0] ST_FULL     = 4'd5;
    localparam logic [UPC_W-1:0] ST_PAD1     = 4'd6;
    localparam logic [UPC_W-1:0] ST_PAD2     = 4'd7;
    localparam logic [UPC_W-1:0] ST_PAD_SP   = 4'd8;
    localparam logic [UPC_W-1:0] ST_PAD_LOOP = 4'd9;
    localparam logic [UPC_W-1:0] ST_PRIME    = 4'd10;
    localparam logic [UPC_W-1:0] ST_DUMP     = 4'd11;
    localparam logic [UPC_W-1:0] ST_NEWLINE  = 4'd12;

    function automatic ctrl_t rom_word(input logic [UPC_W-1:0] a);
        ctrl_t w;
        unique case (a)
            ST_WAIT:     w = '{SRC_NONE,    ACT_ACCEPT,     LAST_NO,  COND_NO_INPUT, ST_WAIT};
            ST_HEX_HI:   w = '{SRC_HEX_HI,  ACT_NONE,       LAST_NO,  COND_NEVER,    ST_WAIT};
            ST_HEX_LO:   w = '{SRC_HEX_LO,  ACT_WRITE,      LAST_LO,  COND_POS_EVEN, ST_BRANCH};
            ST_PAIR_SP:  w = '{SRC_SPACE,   ACT_NONE,       LAST_SP,  COND_NEVER,    ST_WAIT};
            ST_BRANCH:   w = '{SRC_NONE,    ACT_K_FROM_POS, LAST_NO,  COND_NO_LINE,  ST_WAIT};
            ST_FULL:     w = '{SRC_NONE,    ACT_NONE,       LAST_NO,  COND_FULL,     ST_PRIME};
            ST_PAD1:     w = '{SRC_SPACE,   ACT_NONE,       LAST_NO,  COND_NEVER,    ST_WAIT};
            ST_PAD2:     w = '{SRC_SPACE,   ACT_K_INC,      LAST_NO,  COND_K_EVEN,   ST_PAD_LOOP};
            ST_PAD_SP:   w = '{SRC_SPACE,   ACT_NONE,       LAST_NO,  COND_NEVER,    ST_WAIT};
            ST_PAD_LOOP: w = '{SRC_NONE,    ACT_NONE,       LAST_NO,  COND_K_LT_N,   ST_PAD1};
            ST_PRIME:    w = '{SRC_NONE,    ACT_K_CLR,      LAST_NO,  COND_NEVER,    ST_WAIT};
            ST_DUMP:     w = '{SRC_STORE,   ACT_K_NEXT,     LAST_NO,  COND_K_MORE,   ST_DUMP};
            ST_NEWLINE:  w = '{SRC_NEWLINE, ACT_POS_CLR,    LAST_YES, COND_ALWAYS,   ST_WAIT};
            default:     w = '{SRC_NONE,    ACT_NONE,       LAST_NO,  COND_ALWAYS,   ST_WAIT};
        endcase
        return w;
    endfunction

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    logic             taken;

    assign ctrl = rom_word(upc_reg);

    always_comb
    begin
        unique case (ctrl.cond)
            COND_NEVER:    taken = 1'b0;
            COND_ALWAYS:   taken = 1'b1;
            COND_NO_INPUT: taken = flags.no_input;
            COND_POS_EVEN: taken = flags.pos_even;
            COND_NO_LINE:  taken = flags.no_line;
            COND_FULL:     taken = flags.full;
            COND_K_EVEN:   taken = flags.k_even;
            COND_K_LT_N:   taken = flags.k_lt_n;
            COND_K_MORE:   taken = flags.k_more;
            default:       taken = 1'b0;
        endcase
    end

    always_comb
    begin
        upc_next = upc_reg;
        if (advance)
        begin
            upc_next = taken ? ctrl.target : upc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= ST_WAIT;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

/* rtl/hex_dump_formatter.sv */
// ============================================================================
// hex_dump_formatter: byte stream to hex dump text
// Turns a stream of bytes into hex dump text, BYTES_PER_LINE bytes per line,
// one ASCII character per output word.
// ============================================================================
//
//   Channel   Handshake               Payload                Direction
//   input     in_valid / in_stall     data_byte, final_byte  into block
//   output    out_valid / out_stall   out_char, end_of_run   out of block
//
// A byte in the middle of a line runs through the wait step that accepts it,
// two hex digits, an optional pair space and one branch step. Ending a line
// adds a line-end check step, a prime step for the line store read, one dump
// step per stored character and a newline step; padding a partial line runs
// two spaces, an optional pair space and a loop step per missing byte. The
// microcode runs one step per cycle unless an emitting step is stalled; each
// character takes one step. Reset clears the step counter, the line position
// and the output valid; the line store is not cleared. A stall on the output
// freezes an emitting step; a new byte is accepted only in the wait step, while
// the last word of the previous byte may still sit in the output register.
//
module hex_dump_formatter
    import hdf_pkg::*;
#(
    parameter int BYTES_PER_LINE = DEF_BYTES_PER_LINE
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       final_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_char,
    output logic       end_of_run
);

    // The line position must reach BYTES_PER_LINE itself; the store address
    // only needs to index the entries.
    localparam int PW = $clog2(BYTES_PER_LINE + 1);
    localparam int AW = $clog2(BYTES_PER_LINE);
    localparam logic [PW-1:0] LINE_LEN = PW'(BYTES_PER_LINE);

    ctrl_t  ctrl;
    flags_t flags;

    logic          advance;
    logic          emits;
    logic          out_free;
    logic          accept;

    logic [7:0]    byte_reg;
    logic          ends_line_reg;
    logic [PW-1:0] pos_reg;
    logic [PW-1:0] pos_next;
    logic [PW-1:0] k_reg;
    logic [PW-1:0] k_next;

    logic          out_valid_reg;
    logic [7:0]    out_char_reg;
    logic          end_of_run_reg;
    logic [7:0]    char_sel;
    logic          last_sel;

    logic          store_we;
    logic          store_re;
    logic [AW-1:0] store_raddr;
    logic [7:0]    store_rdata;
    logic [PW:0]   k_plus_one;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    hdf_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .flags   (flags),
        .ctrl    (ctrl)
    );

    // A step that emits a character waits until the output register is
    // free or being emptied in this cycle. Other steps always complete.
    assign emits    = (ctrl.src != SRC_NONE);
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = !emits || out_free;

    assign in_stall = (ctrl.act != ACT_ACCEPT);
    assign accept   = in_valid && !in_stall;

    assign k_plus_one = {1'b0, k_reg} + 1'b1;

    always_comb
    begin
        flags.no_input = !in_valid;
        flags.pos_even = !pos_reg[0];
        flags.no_line  = !ends_line_reg;
        flags.full     = (pos_reg == LINE_LEN);
        flags.k_even   = !k_reg[0];
        flags.k_lt_n   = (k_reg < LINE_LEN);
        flags.k_more   = (k_plus_one < {1'b0, pos_reg});
    end

    // ------------------------------------------------------------------
    // Line store
    // ------------------------------------------------------------------
    // The dump loop reads one entry ahead: the prime step fetches entry
    // zero, and every dump step fetches the entry after the one it emits.
    assign store_we    = advance && (ctrl.act == ACT_WRITE);
    assign store_re    = advance && (ctrl.act == ACT_K_CLR || ctrl.act == ACT_K_NEXT);
    assign store_raddr = (ctrl.act == ACT_K_CLR) ? '0 : k_plus_one[AW-1:0];

    hdf_ram #(
        .WIDTH (8),
        .DEPTH (BYTES_PER_LINE)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (pos_reg[AW-1:0]),
        .wdata (printable(byte_reg)),
        .re    (store_re),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_comb
    begin
        pos_next = pos_reg;
        k_next   = k_reg;
        if (advance)
        begin
            case (ctrl.act)
                ACT_WRITE:      pos_next = pos_reg + 1'b1;
                ACT_POS_CLR:    pos_next = '0;
                ACT_K_FROM_POS: k_next   = pos_reg;
                ACT_K_CLR:      k_next   = '0;
                ACT_K_INC:      k_next   = k_reg + 1'b1;
                ACT_K_NEXT:     k_next   = k_plus_one[PW-1:0];
                default:        k_next   = k_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    // The byte, its line-end decision and the loop counter are payload.
    always_ff @(posedge clk)
    begin
        k_reg <= k_next;
        if (accept)
        begin
            byte_reg      <= data_byte;
            ends_line_reg <= final_byte || (pos_reg + 1'b1 == LINE_LEN);
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_comb
    begin
        case (ctrl.src)
            SRC_HEX_HI:  char_sel = hex_char(byte_reg[7:4]);
            SRC_HEX_LO:  char_sel = hex_char(byte_reg[3:0]);
            SRC_STORE:   char_sel = store_rdata;
            SRC_NEWLINE: char_sel = CHAR_NEWLINE;
            default:     char_sel = CHAR_SPACE;
        endcase
    end

    // The low digit closes the word run only when no pair space and no
    // line follow; a pair space closes it when no line follows.
    always_comb
    begin
        case (ctrl.last)
            LAST_LO:  last_sel = !ends_line_reg && !pos_reg[0];
            LAST_SP:  last_sel = !ends_line_reg;
            LAST_YES: last_sel = 1'b1;
            default:  last_sel = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emits && advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emits && advance)
        begin
            out_char_reg   <= char_sel;
            end_of_run_reg <= last_sel;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_char   = out_char_reg;
    assign end_of_run = end_of_run_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTH
    a_pos_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= LINE_LEN)
        else $error("line position beyond line length");

    a_newline_restarts : assert property (@(posedge clk) disable iff (!rst_n)
        (emits && advance && ctrl.src == SRC_NEWLINE) |=> (pos_reg == '0))
        else $error("line position not cleared after newline");

    a_newline_ends_run : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_char == CHAR_NEWLINE && ctrl.src == SRC_NONE && !in_stall)
        |-> end_of_run)
        else $error("newline left waiting without end of run");
`endif

endmodule
